// ===== rtl/number_literal_parser_core_assert.svh =====
// ----------------------------------------------------------------------------
// number_literal_parser_core_assert.svh
// Assertion macros shared by the number literal parser RTL.
// ----------------------------------------------------------------------------
`ifndef NUMBER_LITERAL_PARSER_CORE_ASSERT_SVH
`define NUMBER_LITERAL_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is active
`define NLP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active
`define NLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/nlp_pkg.sv =====
// ----------------------------------------------------------------------------
// nlp_pkg
// Types and constants of the number literal parser.
// ----------------------------------------------------------------------------
package nlp_pkg;

    localparam int unsigned ValueW = 32;

    // Marker returned when a hex literal does not fit in 32 bits
    localparam logic [ValueW-1:0] OvfMarker = 32'hDEAD_0CF1;

    // Character codes
    localparam logic [7:0] ChZero  = 8'h30;  // '0'
    localparam logic [7:0] ChNine  = 8'h39;  // '9'
    localparam logic [7:0] ChUnder = 8'h5F;  // '_'
    localparam logic [7:0] ChApos  = 8'h27;  // apostrophe
    localparam logic [7:0] ChLowX  = 8'h78;  // 'x'
    localparam logic [7:0] ChUpX   = 8'h58;  // 'X'
    localparam logic [7:0] ChLowB  = 8'h62;  // 'b'
    localparam logic [7:0] ChUpB   = 8'h42;  // 'B'
    localparam logic [7:0] ChLowA  = 8'h61;  // 'a'
    localparam logic [7:0] ChLowF  = 8'h66;  // 'f'
    localparam logic [7:0] ChUpA   = 8'h41;  // 'A'
    localparam logic [7:0] ChUpF   = 8'h46;  // 'F'
    localparam logic [7:0] HexSkipBelow = 8'd20;

    // Letter digits sit this far above their low nibble
    localparam logic [3:0] HexLetterOfs = 4'd9;

    // Radix codes as reported on the result channel
    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_HEX = 2'd2,
        RADIX_BIN = 2'd3
    } t_radix;

    // Parse phase, one-hot
    typedef enum logic [4:0] {
        PH_START   = 5'b00001,
        PH_ZERO    = 5'b00010,
        PH_DIGITS  = 5'b00100,
        PH_STOPPED = 5'b01000,
        PH_OVF     = 5'b10000
    } t_phase;

    typedef struct packed {
        t_phase            phase;
        t_radix            radix;
        logic [ValueW-1:0] acc;
    } t_parse_state;

    localparam t_parse_state ParseIdle = '{phase: PH_START, radix: RADIX_DEC, acc: '0};

endpackage

// ===== rtl/nlp_in_if.sv =====
// ----------------------------------------------------------------------------
// nlp_in_if
// Character channel: one byte of the literal per transfer.
// ----------------------------------------------------------------------------
interface nlp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

// ===== rtl/nlp_out_if.sv =====
// ----------------------------------------------------------------------------
// nlp_out_if
// Result channel: one parsed literal per transfer.
// ----------------------------------------------------------------------------
interface nlp_out_if;
    logic                        valid;
    logic                        ready;
    logic [nlp_pkg::ValueW-1:0]  value;
    logic [1:0]                  radix_code;
    logic                        stopped_early;
    logic                        overflow;

    modport source (output valid, output value, output radix_code,
                    output stopped_early, output overflow, input ready);
    modport sink   (input valid, input value, input radix_code,
                    input stopped_early, input overflow, output ready);
endinterface

// ===== rtl/nlp_digit_step.sv =====
// ----------------------------------------------------------------------------
// nlp_digit_step
// Next parse state for one character: prefix decode and digit accumulate.
// ----------------------------------------------------------------------------
module nlp_digit_step (
    input  nlp_pkg::t_parse_state i_state,
    input  logic [7:0]            i_ch,
    output nlp_pkg::t_parse_state o_state
);

    nlp_pkg::t_radix              w_radix;
    nlp_pkg::t_phase              w_dig_phase;
    logic [nlp_pkg::ValueW-1:0]   w_dig_acc;
    logic [7:0]                   w_num;
    logic [3:0]                   w_hex_nib;
    logic                         w_hex_ok;
    logic                         w_sep;

    // Radix used by the digit path: the first character counts as decimal,
    // the one after a leading zero as octal
    always_comb begin
        case (i_state.phase)
            nlp_pkg::PH_START: w_radix = nlp_pkg::RADIX_DEC;
            nlp_pkg::PH_ZERO:  w_radix = nlp_pkg::RADIX_OCT;
            default:           w_radix = i_state.radix;
        endcase
    end

    assign w_sep = (i_ch == nlp_pkg::ChUnder) || (i_ch == nlp_pkg::ChApos);
    assign w_num = i_ch - nlp_pkg::ChZero;

    // Decode a hex digit
    always_comb begin
        w_hex_ok  = 1'b1;
        w_hex_nib = i_ch[3:0];
        if (i_ch inside {[nlp_pkg::ChZero:nlp_pkg::ChNine]}) begin
            w_hex_nib = i_ch[3:0];
        end else if (i_ch inside {[nlp_pkg::ChLowA:nlp_pkg::ChLowF],
                                  [nlp_pkg::ChUpA:nlp_pkg::ChUpF]}) begin
            w_hex_nib = i_ch[3:0] + nlp_pkg::HexLetterOfs;
        end else begin
            w_hex_ok = 1'b0;
        end
    end

    // Accumulate a digit or skip a separator; stop on a bad digit or overflow
    always_comb begin
        w_dig_phase = nlp_pkg::PH_DIGITS;
        w_dig_acc   = i_state.acc;
        if (!w_sep) begin
            case (w_radix)
                nlp_pkg::RADIX_HEX: begin
                    if (i_ch >= nlp_pkg::HexSkipBelow) begin
                        if (!w_hex_ok) begin
                            w_dig_phase = nlp_pkg::PH_STOPPED;
                        end else if (i_state.acc[31:28] != 4'd0) begin
                            w_dig_phase = nlp_pkg::PH_OVF;
                        end else begin
                            w_dig_acc = {i_state.acc[27:0], w_hex_nib};
                        end
                    end
                end
                nlp_pkg::RADIX_BIN: begin
                    if (w_num > 8'd1) begin
                        w_dig_phase = nlp_pkg::PH_STOPPED;
                    end else begin
                        w_dig_acc = {i_state.acc[30:0], w_num[0]};
                    end
                end
                nlp_pkg::RADIX_OCT: begin
                    if (w_num > 8'd7) begin
                        w_dig_phase = nlp_pkg::PH_STOPPED;
                    end else begin
                        w_dig_acc = {i_state.acc[28:0], w_num[2:0]};
                    end
                end
                default: begin
                    if (w_num > 8'd9) begin
                        w_dig_phase = nlp_pkg::PH_STOPPED;
                    end else begin
                        w_dig_acc = {i_state.acc[28:0], 3'd0}
                                  + {i_state.acc[30:0], 1'b0}
                                  + {24'd0, w_num};
                    end
                end
            endcase
        end
    end

    // Advance the parse phase
    always_comb begin
        o_state = i_state;
        case (i_state.phase)
            nlp_pkg::PH_START: begin
                if (i_ch == nlp_pkg::ChZero) begin
                    o_state.phase = nlp_pkg::PH_ZERO;
                    o_state.radix = nlp_pkg::RADIX_OCT;
                end else begin
                    o_state.radix = nlp_pkg::RADIX_DEC;
                    o_state.phase = w_dig_phase;
                    o_state.acc   = w_dig_acc;
                end
            end
            nlp_pkg::PH_ZERO: begin
                o_state.phase = nlp_pkg::PH_DIGITS;
                if ((i_ch == nlp_pkg::ChLowX) || (i_ch == nlp_pkg::ChUpX)) begin
                    o_state.radix = nlp_pkg::RADIX_HEX;
                end else if ((i_ch == nlp_pkg::ChLowB) || (i_ch == nlp_pkg::ChUpB)) begin
                    o_state.radix = nlp_pkg::RADIX_BIN;
                end else begin
                    o_state.radix = nlp_pkg::RADIX_OCT;
                    o_state.phase = w_dig_phase;
                    o_state.acc   = w_dig_acc;
                end
            end
            nlp_pkg::PH_DIGITS: begin
                o_state.phase = w_dig_phase;
                o_state.acc   = w_dig_acc;
            end
            default: begin
                // Stopped or overflowed: ignore the rest of the string
                o_state = i_state;
            end
        endcase
    end

endmodule

// ===== rtl/number_literal_parser_core.sv =====
// ----------------------------------------------------------------------------
// number_literal_parser_core
// Parses an unsigned 32-bit C-style integer literal, one character a cycle.
// ----------------------------------------------------------------------------
// Usage:
//   i_char carries one byte of the literal per transfer; last marks the final
//   byte. After the final byte, o_res presents one result: the value (or the
//   hex overflow marker), the radix, and the stopped/overflow flags. The parse
//   state then returns to its start for the next literal.
// Throughput: one character per cycle, string after string, unless stalled.
// Path: a character is held in an input register, and the digit step works on
//   it there; the result register loads from the digit step as the final byte
//   leaves the input register, unless an earlier result still waits in the
//   output register.
// Reset: synchronous, active low; clears both valid flags and the parse state.
// Stall: while a result waits on o_res, characters that are not final keep
//   flowing; a final character waits in the input register until the output
//   register frees, and i_char.ready drops while that final character waits.
// ----------------------------------------------------------------------------
module number_literal_parser_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    nlp_in_if.sink           i_char,
    nlp_out_if.source        o_res
);

    // Input stage
    logic                        r_in_valid;
    logic [7:0]                  r_in_ch;
    logic                        r_in_last;

    // Parse state
    nlp_pkg::t_parse_state       r_state;
    nlp_pkg::t_parse_state       n_state;

    // Result stage
    logic                        r_out_valid;
    logic [nlp_pkg::ValueW-1:0]  r_out_value;
    logic [1:0]                  r_out_radix;
    logic                        r_out_stopped;
    logic                        r_out_ovf;

    logic                        w_out_free;
    logic                        w_proc_fire;

    nlp_digit_step u_step (
        .i_state (r_state),
        .i_ch    (r_in_ch),
        .o_state (n_state)
    );

    // Handshake
    assign w_out_free   = !r_out_valid || o_res.ready;
    assign w_proc_fire  = r_in_valid && (!r_in_last || w_out_free);
    assign i_char.ready = !r_in_valid || w_proc_fire;

    // Input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.valid && i_char.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    // Input register payload
    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_in_ch   <= i_char.ch;
            r_in_last <= i_char.last;
        end
    end

    // Update parse state; drop back to start after the final character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nlp_pkg::ParseIdle;
        end else if (w_proc_fire) begin
            r_state <= r_in_last ? nlp_pkg::ParseIdle : n_state;
        end
    end

    // Result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc_fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (w_proc_fire && r_in_last) begin
            r_out_value   <= (n_state.phase == nlp_pkg::PH_OVF) ? nlp_pkg::OvfMarker
                                                                : n_state.acc;
            r_out_radix   <= n_state.radix;
            r_out_stopped <= (n_state.phase == nlp_pkg::PH_STOPPED);
            r_out_ovf     <= (n_state.phase == nlp_pkg::PH_OVF);
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.value         = r_out_value;
    assign o_res.radix_code    = r_out_radix;
    assign o_res.stopped_early = r_out_stopped;
    assign o_res.overflow      = r_out_ovf;

    // Checks
`include "number_literal_parser_core_assert.svh"

    `NLP_ASSERT_IMPLY(a_ovf_marker, i_clk, i_rst_n, r_out_valid && r_out_ovf,
        r_out_value == nlp_pkg::OvfMarker, "overflow result without marker value")
    `NLP_ASSERT_IMPLY(a_ovf_is_hex, i_clk, i_rst_n, r_out_valid && r_out_ovf,
        r_out_radix == nlp_pkg::RADIX_HEX, "overflow outside hex radix")
    `NLP_ASSERT_IMPLY(a_flags_excl, i_clk, i_rst_n, r_out_valid,
        !(r_out_stopped && r_out_ovf), "stopped and overflow both set")
    `NLP_ASSERT_NEXT(a_restart, i_clk, i_rst_n, w_proc_fire && r_in_last,
        (r_state.phase == nlp_pkg::PH_START) && (r_state.acc == '0),
        "parse state not cleared after final character")

endmodule
